@@ rtl/fchr_pkg.sv @@
`default_nettype none
package fchr_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] frame_number;
    logic [31:0] checksum_value;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [31:0] stored_checksum;
    logic        matches_res;
  } result_t;

  typedef struct packed {
    logic [31:0] frame;
    logic [31:0] checksum;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [31:0] stored;
  } token_t;

endpackage
`default_nettype wire

@@ rtl/fchr_cell.sv @@
`default_nettype none
module fchr_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift_en,
  input  wire logic            filled,
  input  wire logic [31:0]     query_frame,
  input  wire fchr_pkg::entry_t entry_in,
  output fchr_pkg::entry_t     entry_out,
  input  wire fchr_pkg::token_t tok_in,
  output fchr_pkg::token_t     tok_out
);
  import fchr_pkg::*;

  entry_t entry;
  token_t tok;
  token_t tok_next;
  logic   match;

  assign match = tok_in.valid && !tok_in.hit && filled && (entry.frame == query_frame);

  always_comb begin
    tok_next = tok_in;
    if (match) begin
      tok_next.hit    = 1'b1;
      tok_next.stored = entry.checksum;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_next.valid;
    end
    tok.hit    <= tok_next.hit;
    tok.stored <= tok_next.stored;
  end

  assign entry_out = entry;
  assign tok_out   = tok;

endmodule
`default_nettype wire

@@ rtl/frame_checksum_history_ring.sv @@
// Channel   Signals                 Handshake
// command   start, cmd (cmd_t)      accepted when start is high and busy is low
// result    done, result (result_t) one-cycle strobe on done, cannot be stalled
//
// A record beat shifts the pair into the newest cell and leaves busy low.
// A lookup beat sends a token down the row of DEPTH cells, one cell per cycle; the launch
// register, the DEPTH cell registers and the done register lie between acceptance and the
// strobe, and the result is registered together with done.
// Busy falls in the cycle of the strobe, so the next beat may be accepted then.
// Synchronous reset empties the history and drops any lookup in flight.
`default_nettype none
module frame_checksum_history_ring (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire fchr_pkg::cmd_t   cmd,
  output logic                  done,
  output fchr_pkg::result_t     result
);
  import fchr_pkg::*;

  entry_t            entry_chain [0:DEPTH];
  token_t            tok_chain   [0:DEPTH];
  logic [CNT_W-1:0]  fill_count;
  logic [31:0]       query_frame;
  logic [31:0]       query_expected;
  token_t            launch;
  logic              accept;
  logic              do_record;
  logic              do_lookup;
  token_t            last;

  assign accept    = start && !busy;
  assign do_record = accept && (cmd.action == ACT_RECORD);
  assign do_lookup = accept && (cmd.action == ACT_LOOKUP);

  assign entry_chain[0].frame    = cmd.frame_number;
  assign entry_chain[0].checksum = cmd.checksum_value;
  assign tok_chain[0]            = launch;
  assign last                    = tok_chain[DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (do_record && (fill_count != CNT_W'(DEPTH))) begin
      fill_count <= fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_lookup) begin
      query_frame    <= cmd.frame_number;
      query_expected <= cmd.checksum_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch.valid <= 1'b0;
    end else begin
      launch.valid <= do_lookup;
    end
    launch.hit    <= 1'b0;
    launch.stored <= '0;
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      fchr_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .shift_en    (do_record),
        .filled      (CNT_W'(i) < fill_count),
        .query_frame (query_frame),
        .entry_in    (entry_chain[i]),
        .entry_out   (entry_chain[i+1]),
        .tok_in      (tok_chain[i]),
        .tok_out     (tok_chain[i+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last.valid;
      if (do_lookup) begin
        busy <= 1'b1;
      end else if (last.valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      result.found           <= last.hit;
      result.stored_checksum <= last.stored;
      result.matches_res     <= last.hit && (last.stored == query_expected);
    end
  end

endmodule
`default_nettype wire

@@ rtl/fchr_checker.sv @@
`default_nettype none
module fchr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire fchr_pkg::cmd_t    cmd,
  input wire logic              done,
  input wire fchr_pkg::result_t result
);
  import fchr_pkg::*;

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.action == ACT_LOOKUP)) |=> busy)
    else $error("Lookup beat did not raise busy.");

  a_record_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.action == ACT_RECORD)) |=> (!busy && !done))
    else $error("Record beat caused busy or a result.");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Result strobe lasted more than one cycle.");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("Result strobe without a lookup in flight.");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> ((result.stored_checksum == 32'd0) && !result.matches_res))
    else $error("Missed lookup reported a checksum or a match.");

endmodule

bind frame_checksum_history_ring fchr_checker u_fchr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
`default_nettype wire
